@@ sv/sle_pkg.sv @@
// Package: sizes, codes and request/response types of the sequential list engine.
package sle_pkg;

	localparam int CAPACITY = 64;
	localparam int AW       = $clog2(CAPACITY);
	localparam int LW       = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int KIND_W   = 3;
	localparam int POS_W    = 7;
	localparam int STAT_W   = 2;
	localparam int FIDX_W   = 6;
	localparam int CNT_W    = 7;
	localparam int CW       = ((LW > POS_W) ? LW : POS_W) + 1;

	localparam logic [KIND_W-1:0] K_INSERT = 3'd0;
	localparam logic [KIND_W-1:0] K_DELETE = 3'd1;
	localparam logic [KIND_W-1:0] K_GET    = 3'd2;
	localparam logic [KIND_W-1:0] K_LOCATE = 3'd3;
	localparam logic [KIND_W-1:0] K_CLEAR  = 3'd4;
	localparam logic [KIND_W-1:0] K_APPEND = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [DATA_W-1:0] elem_out;
		logic [FIDX_W-1:0]        found_index;
		logic [CNT_W-1:0]         count;
		logic                     is_empty;
	} rsp_t;

endpackage

@@ sv/sequential_list_engine.sv @@
// Top level: fixed-capacity ordered list kept in a RAM, one request at a time.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------
//  req     | in        | req_valid/req_ready  | kind, position, value
//  rsp     | out       | rsp_valid/rsp_ready  | status, elem_out, found_index, count, is_empty
//
// Clear, error cases and insert or append at the list end need no shifting; insert
// elsewhere shifts the entries from the position onward up, delete shifts those after
// the index down, and locate and append scan the list from the head.
// Shifts and scans are paced by the single RAM port pair: one entry moved or compared per cycle.
// Reset empties the list at once; the RAM content needs no clearing.
// A response waiting on rsp_ready does not block the next request; a request
// that finishes while it waits holds in the last step until the response is taken.
module sequential_list_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  sle_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output sle_pkg::rsp_t rsp
);
	import sle_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EXEC = 4'd1;
	localparam logic [3:0] S_INS  = 4'd2;
	localparam logic [3:0] S_PUT  = 4'd3;
	localparam logic [3:0] S_DEL0 = 4'd4;
	localparam logic [3:0] S_DEL  = 4'd5;
	localparam logic [3:0] S_GET  = 4'd6;
	localparam logic [3:0] S_SCAN = 4'd7;
	localparam logic [3:0] S_RET  = 4'd8;

	logic [3:0]        state_q, state_d;
	req_t              req_q;
	logic [LW-1:0]     len_q, len_d;
	logic [AW-1:0]     cur_q, cur_d;
	logic [STAT_W-1:0] status_q, status_d;
	logic [DATA_W-1:0] elem_q, elem_d;
	logic [AW-1:0]     idx_q, idx_d;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              ram_we;
	logic [AW-1:0]     ram_wa;
	logic [DATA_W-1:0] ram_wd;
	logic [AW-1:0]     ram_ra;
	logic [DATA_W-1:0] rd_data;

	logic [CW-1:0]     pos_ext;
	logic [CW-1:0]     len_ext;
	logic [CW-1:0]     ins_ext;
	logic [AW-1:0]     ins_idx;
	logic [AW-1:0]     pos_idx;
	logic [LW-1:0]     nxt_ext;
	logic              len_full;
	logic              rsp_free;

	sle_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(DATA_W)
	) u_ram (
		.clk(clk),
		.we (ram_we),
		.wa (ram_wa),
		.wd (ram_wd),
		.ra (ram_ra),
		.rd (rd_data)
	);

	assign pos_ext  = CW'(req_q.position);
	assign len_ext  = CW'(len_q);
	assign ins_ext  = pos_ext - CW'(1);
	assign ins_idx  = ins_ext[AW-1:0];
	assign pos_idx  = pos_ext[AW-1:0];
	assign nxt_ext  = LW'(cur_q) + LW'(1);
	assign len_full = (len_ext >= CW'(CAPACITY));
	assign rsp_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_d  = state_q;
		len_d    = len_q;
		cur_d    = cur_q;
		status_d = status_q;
		elem_d   = elem_q;
		idx_d    = idx_q;
		ram_we   = 1'b0;
		ram_wa   = cur_q;
		ram_wd   = rd_data;
		ram_ra   = cur_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					status_d = ST_OK;
					elem_d   = '0;
					idx_d    = '0;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_RET;
				unique case (req_q.kind)
					K_INSERT: begin
						priority if (pos_ext == '0 || pos_ext > len_ext + CW'(1)) begin
							status_d = ST_BAD;
						end else if (len_full) begin
							status_d = ST_FULL;
						end else if (len_ext == ins_ext) begin
							ram_we = 1'b1;
							ram_wa = ins_idx;
							ram_wd = req_q.value;
							len_d  = len_q + LW'(1);
						end else begin
							cur_d   = AW'(len_q - LW'(1));
							ram_ra  = AW'(len_q - LW'(1));
							state_d = S_INS;
						end
					end
					K_DELETE, K_GET: begin
						if (pos_ext >= len_ext) begin
							status_d = ST_BAD;
						end else begin
							cur_d   = pos_idx;
							ram_ra  = pos_idx;
							state_d = (req_q.kind == K_DELETE) ? S_DEL0 : S_GET;
						end
					end
					K_LOCATE, K_APPEND: begin
						if (len_q == '0) begin
							if (req_q.kind == K_LOCATE) begin
								status_d = ST_BAD;
							end else begin
								ram_we = 1'b1;
								ram_wa = '0;
								ram_wd = req_q.value;
								len_d  = LW'(1);
							end
						end else begin
							cur_d   = '0;
							ram_ra  = '0;
							state_d = S_SCAN;
						end
					end
					K_CLEAR: begin
						len_d = '0;
					end
					default: begin
						status_d = ST_BAD;
					end
				endcase
			end
			S_INS: begin
				ram_we = 1'b1;
				ram_wa = cur_q + AW'(1);
				ram_wd = rd_data;
				if (cur_q == ins_idx) begin
					state_d = S_PUT;
				end else begin
					ram_ra = cur_q - AW'(1);
					cur_d  = cur_q - AW'(1);
				end
			end
			S_PUT: begin
				ram_we  = 1'b1;
				ram_wa  = ins_idx;
				ram_wd  = req_q.value;
				len_d   = len_q + LW'(1);
				state_d = S_RET;
			end
			S_DEL0, S_DEL: begin
				if (state_q == S_DEL0) begin
					elem_d = rd_data;
				end else begin
					ram_we = 1'b1;
					ram_wa = cur_q - AW'(1);
					ram_wd = rd_data;
				end
				if (nxt_ext < len_q) begin
					ram_ra  = cur_q + AW'(1);
					cur_d   = cur_q + AW'(1);
					state_d = S_DEL;
				end else begin
					len_d   = len_q - LW'(1);
					state_d = S_RET;
				end
			end
			S_GET: begin
				elem_d  = rd_data;
				state_d = S_RET;
			end
			S_SCAN: begin
				priority if (rd_data == req_q.value) begin
					idx_d   = cur_q;
					state_d = S_RET;
				end else if (nxt_ext < len_q) begin
					ram_ra = cur_q + AW'(1);
					cur_d  = cur_q + AW'(1);
				end else begin
					state_d = S_RET;
					priority if (req_q.kind == K_LOCATE) begin
						status_d = ST_BAD;
					end else if (len_full) begin
						status_d = ST_FULL;
					end else begin
						ram_we = 1'b1;
						ram_wa = AW'(len_q);
						ram_wd = req_q.value;
						idx_d  = AW'(len_q);
						len_d  = len_q + LW'(1);
					end
				end
			end
			S_RET: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			if (state_q == S_RET && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q    <= cur_d;
		status_q <= status_d;
		elem_q   <= elem_d;
		idx_q    <= idx_d;
		if (state_q == S_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == S_RET && rsp_free) begin
			rsp_q.status      <= status_q;
			rsp_q.elem_out    <= elem_q;
			rsp_q.found_index <= FIDX_W'(idx_q);
			rsp_q.count       <= CNT_W'(len_q);
			rsp_q.is_empty    <= (len_q == '0);
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(CAPACITY))
		else $error("list length above capacity");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (LW'(ram_wa) <= len_q))
		else $error("store write beyond list end");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == S_EXEC))
		else $error("accepted request not executed");

	a_len_stable_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && $past(state_q) == S_IDLE) |-> $stable(len_q))
		else $error("list length changed while idle");

endmodule

@@ sv/sle_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with registered read data.
module sle_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wa,
	input  logic [WIDTH-1:0]         wd,
	input  logic [$clog2(DEPTH)-1:0] ra,
	output logic [WIDTH-1:0]         rd
);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[wa] <= wd;
		end
		rd_q <= store_q[ra];
	end

	assign rd = rd_q;

endmodule
